/* src/ard_pkg.sv */
// Shared constants, codes and types of the archive record deframer.
package ard_pkg;

  localparam int ARD_FIFO_DEPTH = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXLEN = 1'd1;

  localparam logic [15:0] MAXLEN_RESET = 16'd255;

  localparam logic [1:0] KIND_DIR    = 2'd0;
  localparam logic [1:0] KIND_FILE   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_COUNT     = 3'd0;
  localparam logic [2:0] ST_EARLY     = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_ZERO_NAME = 3'd3;
  localparam logic [2:0] ST_BAD_TAG   = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  localparam logic [7:0] CH_FILE   = 8'h46;
  localparam logic [7:0] CH_DIR    = 8'h44;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int          HDR_BYTES = 12;
  localparam logic [31:0] HDR_LAST  = 32'(HDR_BYTES - 1);

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] name_offset;
    logic [15:0] name_length;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
    logic        name_safe;
    logic [2:0]  final_status;
  } res_t;

  typedef struct packed {
    logic valid0;
    logic valid1;
    res_t item0;
    res_t item1;
  } push_t;

  typedef struct packed {
    logic space;
    logic full;
  } fifo_stat_t;

endpackage

/* src/ard_if.sv */
// Word channel interfaces: archive byte stream in, deframed results out.
interface ard_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ard_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] name_offset;
  logic [15:0] name_length;
  logic [31:0] payload_offset;
  logic [31:0] payload_length;
  logic        name_safe;
  logic [2:0]  final_status;

  modport source (output valid, output result_kind, output name_offset, output name_length,
                  output payload_offset, output payload_length, output name_safe,
                  output final_status, input ready);
  modport sink (input valid, input result_kind, input name_offset, input name_length,
                input payload_offset, input payload_length, input name_safe,
                input final_status, output ready);
endinterface

/* src/archive_record_deframer_top.sv */
// Archive record deframer: takes an archive one byte word at a time and
// returns one word per directory or file record plus one final status word.
// Channels: in_ch carries data_byte and last_byte; out_ch carries the record
// fields (kind, name offset and length, payload offset and length, name
// verdict, final status). Both complete a word when valid and ready are high.
// cfg_we/cfg_index/cfg_wdata write magic_word (index 0) and max_name_length
// (index 1); write them only while no archive is in flight.
// A byte passes the input register, then its result words enter the queue.
// Throughput: one byte per cycle while in_ch.ready is high; the byte stage and
// the result queue run in one pass per byte. A byte can cause two words
// (record and status), which the queue hands out one after the other.
// Stall: in_ch.ready drops when the result queue holds more than
// FIFO_DEPTH-2 entries; pending words stay in the queue until taken.
// Reset: synchronous on rst_n low; the parser returns to the header phase,
// the queue empties, magic_word becomes 0 and max_name_length 255.
// The parser also restarts on its own after every byte marked last_byte.
module archive_record_deframer_top import ard_pkg::*; #(
  parameter int FIFO_DEPTH = ARD_FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ard_byte_if.sink              in_ch,
  ard_res_if.source             out_ch
);

  logic [63:0] magic_r;
  logic [15:0] maxlen_r;
  logic        in_load;
  push_t       push;
  fifo_stat_t  fstat;
  res_t        out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r  <= 64'd0;
      maxlen_r <= MAXLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAGIC:  magic_r  <= cfg_wdata[63:0];
        REG_MAXLEN: maxlen_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = fstat.space;
  assign in_load     = in_ch.valid && in_ch.ready;

  ard_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_load         (in_load),
    .in_data         (in_ch.data_byte),
    .in_last         (in_ch.last_byte),
    .magic_word      (magic_r),
    .max_name_length (maxlen_r),
    .push            (push)
  );

  ard_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_item  (out_item),
    .stat      (fstat)
  );

  assign out_ch.result_kind    = out_item.result_kind;
  assign out_ch.name_offset    = out_item.name_offset;
  assign out_ch.name_length    = out_item.name_length;
  assign out_ch.payload_offset = out_item.payload_offset;
  assign out_ch.payload_length = out_item.payload_length;
  assign out_ch.name_safe      = out_item.name_safe;
  assign out_ch.final_status   = out_item.final_status;

`ifndef SYNTHESIS
  a_pair_ends_in_status: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid1 |-> push.valid0 && push.item1.result_kind == KIND_STATUS)
    else $error("second result of a byte is not a status");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid0 |-> !fstat.full)
    else $error("result queue overflow");

  a_ready_tracks_room: assert property (@(posedge clk) disable iff (!rst_n)
    $past(fstat.full) && fstat.full |-> !in_ch.ready)
    else $error("input taken while result queue full");
`endif

endmodule

/* src/ard_parser.sv */
// Byte parser: input register, record/field state and result assembly.
module ard_parser import ard_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_load,
  input  logic [7:0]  in_data,
  input  logic        in_last,
  input  logic [63:0] magic_word,
  input  logic [15:0] max_name_length,
  output push_t       push
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_TAG    = 3'd1;
  localparam logic [2:0] PH_NLEN   = 3'd2;
  localparam logic [2:0] PH_NAME   = 3'd3;
  localparam logic [2:0] PH_DLEN   = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  logic        vld_r;
  logic [7:0]  byte_r;
  logic        last_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] target_r, target_nxt;
  logic [31:0] recs_r, recs_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic        tag_file_r, tag_file_nxt;
  logic        tag_known_r, tag_known_nxt;
  logic [15:0] name_len_r, name_len_nxt;
  logic [31:0] name_off_r, name_off_nxt;
  logic [31:0] data_off_r, data_off_nxt;
  logic [31:0] left_r, left_nxt;
  logic        unsafe_r, unsafe_nxt;
  logic [1:0]  comp_len_r, comp_len_nxt;
  logic        dots_r, dots_nxt;
  logic [1:0]  nidx_r, nidx_nxt;
  logic        magic_ok_r, magic_ok_nxt;

  logic        rec_emit;
  logic [1:0]  rec_kind;
  logic [31:0] rec_poff;
  logic [31:0] rec_plen;
  logic        rec_unsafe;
  logic        st_emit;
  logic [2:0]  st_code;
  logic [31:0] sh;
  logic [31:0] left_dec;
  logic [31:0] recs_inc;
  logic [7:0]  magic_byte;
  res_t        rec_item;
  res_t        st_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_load;
    end
    if (in_load) begin
      byte_r <= in_data;
      last_r <= in_last;
    end
  end

  assign magic_byte = magic_word[(7 - pos_r[2:0]) * 8 +: 8];
  assign sh         = {shift_r[23:0], byte_r};
  assign left_dec   = left_r - 32'd1;
  assign recs_inc   = recs_r + 32'd1;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    target_nxt    = target_r;
    recs_nxt      = recs_r;
    shift_nxt     = shift_r;
    fidx_nxt      = fidx_r;
    tag_file_nxt  = tag_file_r;
    tag_known_nxt = tag_known_r;
    name_len_nxt  = name_len_r;
    name_off_nxt  = name_off_r;
    data_off_nxt  = data_off_r;
    left_nxt      = left_r;
    unsafe_nxt    = unsafe_r;
    comp_len_nxt  = comp_len_r;
    dots_nxt      = dots_r;
    nidx_nxt      = nidx_r;
    magic_ok_nxt  = magic_ok_r;
    rec_emit      = 1'b0;
    rec_kind      = KIND_DIR;
    rec_poff      = 32'd0;
    rec_plen      = 32'd0;
    rec_unsafe    = unsafe_r;
    st_emit       = 1'b0;
    st_code       = ST_COUNT;

    if (vld_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (pos_r[31:3] == 29'd0) begin
            if (magic_byte != byte_r) begin
              magic_ok_nxt = 1'b0;
            end
          end else begin
            shift_nxt = sh;
            if (pos_r == HDR_LAST) begin
              target_nxt = sh;
              shift_nxt  = 32'd0;
              if (!magic_ok_r) begin
                st_emit = 1'b1;
                st_code = ST_BAD_HDR;
              end else if (sh == 32'd0) begin
                st_emit = 1'b1;
                st_code = ST_COUNT;
              end else begin
                phase_nxt = PH_TAG;
              end
            end
          end
        end
        PH_TAG: begin
          tag_file_nxt  = (byte_r == CH_FILE);
          tag_known_nxt = (byte_r == CH_FILE) || (byte_r == CH_DIR);
          shift_nxt     = 32'd0;
          fidx_nxt      = 3'd0;
          phase_nxt     = PH_NLEN;
        end
        PH_NLEN: begin
          shift_nxt = sh;
          fidx_nxt  = fidx_r + 3'd1;
          if (fidx_r == 3'd1) begin
            name_len_nxt = sh[15:0];
            name_off_nxt = pos_r + 32'd1;
            shift_nxt    = 32'd0;
            fidx_nxt     = 3'd0;
            if (sh[15:0] == 16'd0) begin
              st_emit = 1'b1;
              st_code = ST_ZERO_NAME;
            end else begin
              left_nxt     = {16'd0, sh[15:0]};
              unsafe_nxt   = sh[15:0] > max_name_length;
              comp_len_nxt = 2'd0;
              dots_nxt     = 1'b1;
              nidx_nxt     = 2'd0;
              phase_nxt    = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (byte_r == CH_NUL || byte_r == CH_BSLASH) begin
            unsafe_nxt = 1'b1;
          end
          if (nidx_r == 2'd0 && byte_r == CH_SLASH) begin
            unsafe_nxt = 1'b1;
          end
          if (nidx_r == 2'd1 && byte_r == CH_COLON) begin
            unsafe_nxt = 1'b1;
          end
          if (nidx_r != 2'd3) begin
            nidx_nxt = nidx_r + 2'd1;
          end
          if (byte_r == CH_SLASH) begin
            if (dots_r && (comp_len_r == 2'd1 || comp_len_r == 2'd2)) begin
              unsafe_nxt = 1'b1;
            end
            comp_len_nxt = 2'd0;
            dots_nxt     = 1'b1;
          end else begin
            if (comp_len_r != 2'd3) begin
              comp_len_nxt = comp_len_r + 2'd1;
            end
            if (byte_r != CH_DOT) begin
              dots_nxt = 1'b0;
            end
          end
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            if (dots_nxt && (comp_len_nxt == 2'd1 || comp_len_nxt == 2'd2)) begin
              unsafe_nxt = 1'b1;
            end
            comp_len_nxt = 2'd0;
            dots_nxt     = 1'b1;
            if (!tag_known_r) begin
              st_emit = 1'b1;
              st_code = ST_BAD_TAG;
            end else if (tag_file_r) begin
              phase_nxt = PH_DLEN;
            end else begin
              rec_emit = 1'b1;
              rec_kind = KIND_DIR;
            end
          end
        end
        PH_DLEN: begin
          shift_nxt = sh;
          fidx_nxt  = fidx_r + 3'd1;
          if (fidx_r == 3'd3) begin
            fidx_nxt = 3'd0;
            if (sh == 32'd0) begin
              rec_emit = 1'b1;
              rec_kind = KIND_FILE;
              rec_poff = pos_r + 32'd1;
            end else begin
              left_nxt     = sh;
              data_off_nxt = pos_r + 32'd1;
              phase_nxt    = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            rec_emit = 1'b1;
            rec_kind = KIND_FILE;
            rec_poff = data_off_r;
            rec_plen = shift_r;
          end
        end
        default: begin
        end
      endcase

      if (rec_emit) begin
        recs_nxt = recs_inc;
        if (recs_inc == target_r) begin
          st_emit = 1'b1;
          st_code = ST_COUNT;
        end else begin
          phase_nxt = PH_TAG;
        end
      end
      if (st_emit) begin
        phase_nxt = PH_DONE;
      end

      pos_nxt    = pos_r + 32'd1;
      rec_unsafe = unsafe_nxt;

      if (last_r) begin
        if (phase_nxt != PH_DONE) begin
          st_emit = 1'b1;
          if (phase_nxt == PH_HEADER) begin
            st_code = ST_BAD_HDR;
          end else if (phase_nxt == PH_TAG) begin
            st_code = ST_EARLY;
          end else begin
            st_code = ST_TRUNC;
          end
        end
        phase_nxt     = PH_HEADER;
        pos_nxt       = 32'd0;
        target_nxt    = 32'd0;
        recs_nxt      = 32'd0;
        shift_nxt     = 32'd0;
        fidx_nxt      = 3'd0;
        tag_file_nxt  = 1'b0;
        tag_known_nxt = 1'b0;
        name_len_nxt  = 16'd0;
        name_off_nxt  = 32'd0;
        data_off_nxt  = 32'd0;
        left_nxt      = 32'd0;
        unsafe_nxt    = 1'b0;
        comp_len_nxt  = 2'd0;
        dots_nxt      = 1'b1;
        nidx_nxt      = 2'd0;
        magic_ok_nxt  = 1'b1;
      end
    end
  end

  always_comb begin
    rec_item.result_kind    = rec_kind;
    rec_item.name_offset    = name_off_r;
    rec_item.name_length    = name_len_r;
    rec_item.payload_offset = rec_poff;
    rec_item.payload_length = rec_plen;
    rec_item.name_safe      = !rec_unsafe;
    rec_item.final_status   = ST_COUNT;

    st_item.result_kind     = KIND_STATUS;
    st_item.name_offset     = 32'd0;
    st_item.name_length     = 16'd0;
    st_item.payload_offset  = 32'd0;
    st_item.payload_length  = 32'd0;
    st_item.name_safe       = 1'b0;
    st_item.final_status    = st_code;

    push.valid0 = rec_emit || st_emit;
    push.valid1 = rec_emit && st_emit;
    push.item0  = rec_emit ? rec_item : st_item;
    push.item1  = st_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= 32'd0;
      target_r    <= 32'd0;
      recs_r      <= 32'd0;
      shift_r     <= 32'd0;
      fidx_r      <= 3'd0;
      tag_file_r  <= 1'b0;
      tag_known_r <= 1'b0;
      name_len_r  <= 16'd0;
      name_off_r  <= 32'd0;
      data_off_r  <= 32'd0;
      left_r      <= 32'd0;
      unsafe_r    <= 1'b0;
      comp_len_r  <= 2'd0;
      dots_r      <= 1'b1;
      nidx_r      <= 2'd0;
      magic_ok_r  <= 1'b1;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      target_r    <= target_nxt;
      recs_r      <= recs_nxt;
      shift_r     <= shift_nxt;
      fidx_r      <= fidx_nxt;
      tag_file_r  <= tag_file_nxt;
      tag_known_r <= tag_known_nxt;
      name_len_r  <= name_len_nxt;
      name_off_r  <= name_off_nxt;
      data_off_r  <= data_off_nxt;
      left_r      <= left_nxt;
      unsafe_r    <= unsafe_nxt;
      comp_len_r  <= comp_len_nxt;
      dots_r      <= dots_nxt;
      nidx_r      <= nidx_nxt;
      magic_ok_r  <= magic_ok_nxt;
    end
  end

endmodule

/* src/ard_result_fifo.sv */
// Result queue: one entry per parsed byte that yields results, holding one or two results.
module ard_result_fifo import ard_pkg::*; #(
  parameter int DEPTH = ARD_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  input  logic       out_ready,
  output logic       out_valid,
  output res_t       out_item,
  output fifo_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic two;
    res_t a;
    res_t b;
  } entry_t;

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          sub_r, sub_nxt;
  logic          pop;
  entry_t        head;

  assign head      = mem[rd_r];
  assign out_valid = (cnt_r != '0);
  assign out_item  = sub_r ? head.b : head.a;
  assign pop       = out_valid && out_ready && (sub_r || !head.two);

  assign stat.space = (cnt_r <= CW'(DEPTH - 2));
  assign stat.full  = (cnt_r == CW'(DEPTH));

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    sub_nxt = sub_r;
    if (push.valid0) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (out_valid && out_ready) begin
      sub_nxt = !pop;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    case ({push.valid0, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      mem[wr_r] <= '{two: push.valid1, a: push.item0, b: push.item1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      sub_r <= 1'b0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
    end
  end

endmodule

/* tb/sv/archive_record_deframer_top_tb.sv */
// Self-checking bench: archive byte words in, record and status words checked.
module archive_record_deframer_top_tb import ard_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_BYTES = 300;

  typedef enum logic [2:0] {
    PH_HDR, PH_TAG, PH_NLEN, PH_NAME, PH_DLEN, PH_DATA, PH_DONE
  } phase_t;

  typedef struct {
    logic [7:0] b;
    bit         lst;
    bit         typed;
    logic [2:0] st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ard_byte_if in_ch();
  ard_res_if out_ch();

  archive_record_deframer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser model state
  logic [63:0] magic_cfg;
  logic [15:0] maxlen_cfg;
  phase_t ph;
  logic [31:0] pos, target, recs_seen, acc, nm_off, remain;
  logic [2:0] acc_idx;
  logic [15:0] nm_len;
  logic [1:0] comp_len;
  bit is_file, tag_ok, unsafe, comp_dots, magic_ok, done;

  res_t pending_words[$];
  logic [7:0] arc_q[$];

  int send_idle, recv_idle;
  int bytes_parsed, archives_sent, words_checked, mismatches, stall_cycles, cycle_count;
  int hold_left;
  bit hold_done;
  logic hold_req;

  dir_row_t dir_rows [30] = '{
    '{8'h00, 1'b1, 1'b1, ST_BAD_HDR},
    '{8'h00, 1'b0, 1'b0, ST_COUNT}, '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT}, '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT}, '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT}, '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT}, '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b1, ST_COUNT},
    '{8'hFF, 1'b1, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT}, '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT}, '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT}, '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT}, '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT}, '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h01, 1'b0, 1'b0, ST_COUNT},
    '{CH_DIR, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b0, ST_COUNT},
    '{8'h00, 1'b0, 1'b1, ST_ZERO_NAME},
    '{8'h5A, 1'b1, 1'b0, ST_COUNT}
  };

  function automatic string word_str(res_t w);
    return $sformatf("kind %0d name @%h len %0d payload @%h len %0d safe %0d status %0d",
                     w.result_kind, w.name_offset, w.name_length, w.payload_offset,
                     w.payload_length, w.name_safe, w.final_status);
  endfunction

  function automatic res_t status_word(logic [2:0] st);
    res_t w;
    w = '0;
    w.result_kind = KIND_STATUS;
    w.final_status = st;
    return w;
  endfunction

  function automatic void clear_parser();
    ph = PH_HDR;
    pos = '0;
    target = '0;
    recs_seen = '0;
    acc = '0;
    acc_idx = '0;
    is_file = 1'b0;
    tag_ok = 1'b0;
    nm_len = '0;
    nm_off = '0;
    remain = '0;
    unsafe = 1'b0;
    comp_len = '0;
    comp_dots = 1'b1;
    magic_ok = 1'b1;
    done = 1'b0;
  endfunction

  function automatic void put_status(logic [2:0] st);
    pending_words = {pending_words, status_word(st)};
    done = 1'b1;
    ph = PH_DONE;
  endfunction

  function automatic void put_record(logic [1:0] kind, logic [31:0] poff, logic [31:0] plen);
    res_t w;
    w = '0;
    w.result_kind = kind;
    w.name_offset = nm_off;
    w.name_length = nm_len;
    w.payload_offset = poff;
    w.payload_length = plen;
    w.name_safe = !unsafe;
    pending_words = {pending_words, w};
    recs_seen++;
    if (recs_seen == target) put_status(ST_COUNT);
    else ph = PH_TAG;
  endfunction

  function automatic void close_component();
    if (comp_dots && (comp_len == 2'd1 || comp_len == 2'd2)) unsafe = 1'b1;
    comp_len = '0;
    comp_dots = 1'b1;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, input bit lst, output bit counted);
    logic [31:0] idx;
    counted = (ph != PH_DONE);
    case (ph)
      PH_HDR: begin
        if (pos < 8) begin
          if (magic_cfg[8 * (7 - int'(pos)) +: 8] != b) magic_ok = 1'b0;
        end else begin
          acc = {acc[23:0], b};
          if (pos == HDR_LAST) begin
            target = acc;
            acc = '0;
            if (!magic_ok) put_status(ST_BAD_HDR);
            else if (target == 0) put_status(ST_COUNT);
            else ph = PH_TAG;
          end
        end
      end
      PH_TAG: begin
        is_file = (b == CH_FILE);
        tag_ok = (b == CH_FILE) || (b == CH_DIR);
        acc = '0;
        acc_idx = '0;
        ph = PH_NLEN;
      end
      PH_NLEN: begin
        acc = {acc[23:0], b};
        acc_idx++;
        if (acc_idx == 3'd2) begin
          nm_len = acc[15:0];
          nm_off = pos + 1;
          acc = '0;
          acc_idx = '0;
          if (nm_len == 0) begin
            put_status(ST_ZERO_NAME);
          end else begin
            remain = 32'(nm_len);
            unsafe = nm_len > maxlen_cfg;
            comp_len = '0;
            comp_dots = 1'b1;
            ph = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        idx = 32'(nm_len) - remain;
        if (b == CH_NUL || b == CH_BSLASH) unsafe = 1'b1;
        if (idx == 0 && b == CH_SLASH) unsafe = 1'b1;
        if (idx == 1 && b == CH_COLON) unsafe = 1'b1;
        if (b == CH_SLASH) begin
          close_component();
        end else begin
          if (comp_len != 2'd3) comp_len++;
          if (b != CH_DOT) comp_dots = 1'b0;
        end
        remain--;
        if (remain == 0) begin
          close_component();
          if (!tag_ok) put_status(ST_BAD_TAG);
          else if (is_file) ph = PH_DLEN;
          else put_record(KIND_DIR, '0, '0);
        end
      end
      PH_DLEN: begin
        acc = {acc[23:0], b};
        acc_idx++;
        if (acc_idx == 3'd4) begin
          acc_idx = '0;
          if (acc == 0) begin
            put_record(KIND_FILE, pos + 1, '0);
          end else begin
            remain = acc;
            ph = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        remain--;
        if (remain == 0) put_record(KIND_FILE, pos + 1 - acc, acc);
      end
      default: ;
    endcase
    pos++;
    if (lst) begin
      if (!done) put_status(ph == PH_HDR ? ST_BAD_HDR : (ph == PH_TAG ? ST_EARLY : ST_TRUNC));
      clear_parser();
    end
  endtask

  task automatic put_byte(input logic [7:0] b, input bit lst, input bit typed,
                          input logic [2:0] st);
    int n0;
    bit counted;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n0 = pending_words.size();
    deframe_byte(b, lst, counted);
    if (typed) begin
      while (pending_words.size() > n0) pending_words.delete(pending_words.size() - 1);
      pending_words = {pending_words, status_word(st)};
    end
    if (counted) bytes_parsed++;
  endtask

  function automatic void push_be(logic [31:0] v, int nb);
    for (int i = nb - 1; i >= 0; i--) arc_q = {arc_q, v[8 * i +: 8]};
  endfunction

  task automatic build_archive();
    int style, n_rec, bad_rec, zero_rec, nlen, pick, cut;
    logic [31:0] count, dlen;
    logic [63:0] magic;
    logic [7:0] tag, ch;
    bit is_f;
    arc_q.delete();
    style = $urandom_range(99);
    if (style < 6) begin
      repeat ($urandom_range(1, 16)) arc_q = {arc_q, 8'($urandom)};
      return;
    end
    n_rec = $urandom_range(1, 4);
    count = n_rec;
    if (style < 8) count = 32'hFFFF_FFFF;
    else if (style < 14) count = n_rec + $urandom_range(1, 3);
    else if (style < 18) count = '0;
    else if (style >= 85) count = n_rec + 1;
    magic = magic_cfg;
    if (style >= 18 && style < 24) magic[$urandom_range(63)] ^= 1'b1;
    for (int i = 7; i >= 0; i--) arc_q = {arc_q, magic[8 * i +: 8]};
    push_be(count, 4);
    bad_rec = (style >= 24 && style < 30) ? $urandom_range(n_rec - 1) : -1;
    zero_rec = (style >= 30 && style < 34) ? $urandom_range(n_rec - 1) : -1;
    for (int r = 0; r < n_rec; r++) begin
      is_f = 1'($urandom_range(1));
      tag = is_f ? CH_FILE : CH_DIR;
      if (r == bad_rec) begin
        do tag = 8'($urandom); while (tag == CH_FILE || tag == CH_DIR);
      end
      nlen = (r == zero_rec) ? 0 : $urandom_range(1, 6);
      arc_q = {arc_q, tag};
      push_be(32'(nlen), 2);
      for (int k = 0; k < nlen; k++) begin
        pick = $urandom_range(99);
        if (pick < 40) ch = 8'h61 + 8'($urandom_range(25));
        else if (pick < 62) ch = CH_DOT;
        else if (pick < 82) ch = CH_SLASH;
        else if (pick < 87) ch = CH_COLON;
        else if (pick < 90) ch = CH_BSLASH;
        else if (pick < 93) ch = CH_NUL;
        else ch = 8'($urandom);
        arc_q = {arc_q, ch};
      end
      if (is_f) begin
        dlen = $urandom_range(0, 5);
        push_be(dlen, 4);
        repeat (dlen) arc_q = {arc_q, 8'($urandom)};
      end
    end
    if (style >= 34 && style < 85 && $urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) arc_q = {arc_q, 8'($urandom)};
    end
    if (style >= 85) begin
      if ($urandom_range(1)) begin
        arc_q = {arc_q, CH_FILE};
        push_be(32'($urandom_range(1, 3)), 2);
        repeat (3) arc_q = {arc_q, 8'($urandom)};
        push_be(32'hFFFF_FFFF, 4);
      end else begin
        arc_q = {arc_q, CH_DIR};
        push_be(32'h0000_FFFF, 2);
      end
      repeat (3) arc_q = {arc_q, 8'($urandom)};
      cut = $urandom_range(arc_q.size() - 1);
      arc_q = arc_q[0:cut];
    end
  endtask

  task automatic send_archive();
    build_archive();
    foreach (arc_q[i]) put_byte(arc_q[i], i == arc_q.size() - 1, 1'b0, ST_COUNT);
    archives_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(logic [63:0] magic, logic [15:0] maxlen);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= REG_MAXLEN;
    cfg_wdata <= CFG_DATA_W'(maxlen);
    @(posedge clk);
    cfg_we <= 1'b0;
    magic_cfg = magic;
    maxlen_cfg = maxlen;
  endtask

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    res_t got, want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && in_ch.valid && !in_ch.ready) stall_cycles++;
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.result_kind = out_ch.result_kind;
        got.name_offset = out_ch.name_offset;
        got.name_length = out_ch.name_length;
        got.payload_offset = out_ch.payload_offset;
        got.payload_length = out_ch.payload_length;
        got.name_safe = out_ch.name_safe;
        got.final_status = out_ch.final_status;
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %s", word_str(got));
        end else begin
          want = pending_words.pop_front();
          words_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word %0d mismatch", words_checked);
              $display("  expected %s", word_str(want));
              $display("  actual   %s", word_str(got));
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    int goal;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MAGIC;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    hold_req <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    magic_cfg = '0;
    maxlen_cfg = MAXLEN_RESET;
    clear_parser();
    send_idle = 33;
    recv_idle = 61;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      put_byte(dir_rows[i].b, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].st);
    end
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config({$urandom, $urandom}, MAXLEN_RESET);
        1: set_config(64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
        2: set_config({$urandom, $urandom}, 16'hFFFF);
        3: set_config(64'd0, 16'd3);
        4: set_config({$urandom, $urandom}, 16'd2);
        default: set_config({$urandom, $urandom}, 16'($urandom_range(1, 8)));
      endcase
      send_idle = (p < 2) ? 33 : ((p < 4) ? 61 : 0);
      recv_idle = (p < 2) ? 61 : ((p < 4) ? 33 : 0);
      if (p == 2) hold_req <= 1'b1;
      goal = bytes_parsed + PHASE_BYTES;
      while (bytes_parsed < goal) send_archive();
    end
    drain();
    $display("covered %0d archives and %0d parsed bytes over six register settings",
             archives_sent, bytes_parsed);
    $display("%0d words checked, input held off for %0d cycles by back-pressure; %0d mismatches",
             words_checked, stall_cycles, mismatches);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
